// ===== rtl/srdt_pkg.sv =====
package srdt_pkg;

  localparam int COORD_IN_W = 16;
  localparam int COUNT_W    = 12;
  localparam int CAP_W      = 12;
  localparam int DIST_W     = 24;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 1;
  localparam int STATUS_W   = 2;

  localparam logic [CAP_W-1:0]  CAP_RESET  = 12'd320;
  localparam logic [DIST_W-1:0] DIST_RESET = 24'd4096;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST_SQ = 1'd1;

  localparam logic OP_BEGIN = 1'b0;
  localparam logic OP_OFFER = 1'b1;

  localparam logic [STATUS_W-1:0] ST_STORED    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_CLEARED   = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                load;
    logic                clear;
    logic                store;
    logic                scan_start;
    logic                scan_issue;
    logic                finish;
    logic [STATUS_W-1:0] status;
  } srdt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic op;
    logic full;
    logic empty;
    logic scan_last;
    logic pipe_busy;
    logic dup;
    logic out_free;
  } srdt_stat_t;

endpackage

// ===== rtl/srdt_if.sv =====
interface srdt_in_if;
  logic                              valid;
  logic                              ready;
  logic                              op;
  logic [srdt_pkg::COORD_IN_W-1:0]   left_x;
  logic [srdt_pkg::COORD_IN_W-1:0]   left_y;
  logic [srdt_pkg::COORD_IN_W-1:0]   right_x;
  logic [srdt_pkg::COORD_IN_W-1:0]   right_y;
  logic                              count_insert;

  modport source(output valid, op, left_x, left_y, right_x, right_y, count_insert,
                 input ready);
  modport sink(input valid, op, left_x, left_y, right_x, right_y, count_insert,
               output ready);
endinterface

interface srdt_out_if;
  logic                            valid;
  logic                            ready;
  logic [srdt_pkg::STATUS_W-1:0]   status;
  logic [srdt_pkg::COUNT_W-1:0]    stored_count;
  logic [srdt_pkg::COUNT_W-1:0]    inserted_count;

  modport source(output valid, status, stored_count, inserted_count, input ready);
  modport sink(input valid, status, stored_count, inserted_count, output ready);
endinterface

// ===== rtl/stereo_pair_radius_dedup_table.sv =====
// A begin item, an offer to a full table or an offer to an empty table goes from the
// evaluate state straight to the finish state and gives its result without a scan.
// Any other offer is checked against every stored pair: the table RAM is read one entry
// per cycle, followed by a two-stage distance compare.
// A new request is taken in the cycle after the result is registered.
// Synchronous active-low reset empties the table and loads the register defaults.
module stereo_pair_radius_dedup_table #(
  parameter int TABLE_DEPTH = 2048,
  parameter int COORD_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [srdt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [srdt_pkg::CFG_DATA_W-1:0] cfg_data,
  srdt_in_if.sink                         in_chan,
  srdt_out_if.source                      out_chan
);

  srdt_pkg::srdt_cmd_t  cmd;
  srdt_pkg::srdt_stat_t stat;

  srdt_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_chan.valid),
    .in_ready(in_chan.ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  srdt_datapath #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .COORD_WIDTH(COORD_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_op          (in_chan.op),
    .in_left_x      (in_chan.left_x),
    .in_left_y      (in_chan.left_y),
    .in_right_x     (in_chan.right_x),
    .in_right_y     (in_chan.right_y),
    .in_count_insert(in_chan.count_insert),
    .cmd            (cmd),
    .stat           (stat),
    .out_chan       (out_chan)
  );

endmodule

// ===== rtl/srdt_ram.sv =====
module srdt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/srdt_ctrl.sv =====
module srdt_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  srdt_pkg::srdt_stat_t stat,
  output srdt_pkg::srdt_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EVAL   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]                    state_r, state_nxt;
  logic [srdt_pkg::STATUS_W-1:0] pend_r, pend_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    pend_nxt       = pend_r;
    cmd            = '0;
    cmd.status     = pend_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        state_nxt = S_FINISH;
        if (stat.op == srdt_pkg::OP_BEGIN) begin
          pend_nxt = srdt_pkg::ST_CLEARED;
        end else if (stat.full) begin
          pend_nxt = srdt_pkg::ST_FULL;
        end else if (stat.empty) begin
          pend_nxt = srdt_pkg::ST_STORED;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (stat.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // The duplicate flag is final once the compare pipeline is empty.
        if (!stat.pipe_busy) begin
          pend_nxt  = stat.dup ? srdt_pkg::ST_DUPLICATE : srdt_pkg::ST_STORED;
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          cmd.store  = (pend_r == srdt_pkg::ST_STORED);
          cmd.clear  = (pend_r == srdt_pkg::ST_CLEARED);
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r  <= srdt_pkg::ST_STORED;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

  a_scan_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_start |-> !stat.empty && !stat.full)
    else $error("scan started on an empty or full table");

  a_store_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL && stat.op == srdt_pkg::OP_OFFER && stat.full) |=>
    pend_r == srdt_pkg::ST_FULL)
    else $error("full table did not give a full status");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> state_r == S_IDLE)
    else $error("controller did not return to idle after a result");

endmodule

// ===== rtl/srdt_datapath.sv =====
module srdt_datapath #(
  parameter int TABLE_DEPTH = 2048,
  parameter int COORD_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [srdt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [srdt_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_op,
  input  logic [srdt_pkg::COORD_IN_W-1:0]     in_left_x,
  input  logic [srdt_pkg::COORD_IN_W-1:0]     in_left_y,
  input  logic [srdt_pkg::COORD_IN_W-1:0]     in_right_x,
  input  logic [srdt_pkg::COORD_IN_W-1:0]     in_right_y,
  input  logic                                in_count_insert,
  input  srdt_pkg::srdt_cmd_t                 cmd,
  output srdt_pkg::srdt_stat_t                stat,
  srdt_out_if.source                          out_chan
);

  localparam int CW    = COORD_WIDTH;
  localparam int AW    = TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int LW    = CNT_W > srdt_pkg::CAP_W ? CNT_W : srdt_pkg::CAP_W;
  localparam int SQ_W  = 2 * CW;
  localparam int SW    = SQ_W + 1 > srdt_pkg::DIST_W ? SQ_W + 1 : srdt_pkg::DIST_W;
  localparam int PW    = 4 * CW;

  logic [srdt_pkg::CAP_W-1:0]  cap_r;
  logic [srdt_pkg::DIST_W-1:0] dist_r;
  logic                        op_r;
  logic                        cnt_ins_r;
  logic [PW-1:0]               pair_r;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [CNT_W-1:0]            ins_r, ins_nxt;
  logic [AW-1:0]               idx_r;
  logic                        rd_valid_r;
  logic                        s1_valid_r;
  logic                        dup_r;
  logic [SQ_W-1:0]             sq_lx_r, sq_ly_r, sq_rx_r, sq_ry_r;
  logic [PW-1:0]               rdata;
  logic                        out_valid_r;
  logic [srdt_pkg::STATUS_W-1:0] out_status_r;
  logic [srdt_pkg::COUNT_W-1:0]  out_stored_r;
  logic [srdt_pkg::COUNT_W-1:0]  out_inserted_r;

  function automatic logic [SQ_W-1:0] sq_delta(input logic [CW-1:0] a,
                                                input logic [CW-1:0] b);
    logic [CW-1:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return SQ_W'(d) * SQ_W'(d);
  endfunction

  srdt_ram #(
    .WIDTH(PW),
    .DEPTH(TABLE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (cmd.store),
    .waddr(cnt_r[AW-1:0]),
    .wdata(pair_r),
    .raddr(idx_r),
    .rdata(rdata)
  );

  // Stored coordinates are packed left x, left y, right x, right y from the top.
  logic [CW-1:0] e_lx, e_ly, e_rx, e_ry;
  logic [CW-1:0] p_lx, p_ly, p_rx, p_ry;
  assign {e_lx, e_ly, e_rx, e_ry} = rdata;
  assign {p_lx, p_ly, p_rx, p_ry} = pair_r;

  logic [SW-1:0] sum_left, sum_right;
  logic          hit;
  assign sum_left  = SW'(sq_lx_r) + SW'(sq_ly_r);
  assign sum_right = SW'(sq_rx_r) + SW'(sq_ry_r);
  assign hit = s1_valid_r && (sum_left <= SW'(dist_r)) && (sum_right <= SW'(dist_r));

  always_comb begin
    cnt_nxt = cnt_r;
    ins_nxt = ins_r;
    if (cmd.clear) begin
      cnt_nxt = '0;
      ins_nxt = '0;
    end else if (cmd.store) begin
      cnt_nxt = cnt_r + CNT_W'(1);
      ins_nxt = ins_r + CNT_W'(cnt_ins_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= srdt_pkg::CAP_RESET;
      dist_r      <= srdt_pkg::DIST_RESET;
      cnt_r       <= '0;
      ins_r       <= '0;
      rd_valid_r  <= 1'b0;
      s1_valid_r  <= 1'b0;
      dup_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          srdt_pkg::CFG_CAPACITY:    cap_r  <= cfg_data[srdt_pkg::CAP_W-1:0];
          srdt_pkg::CFG_MIN_DIST_SQ: dist_r <= cfg_data[srdt_pkg::DIST_W-1:0];
          default: ;
        endcase
      end
      cnt_r      <= cnt_nxt;
      ins_r      <= ins_nxt;
      rd_valid_r <= cmd.scan_issue;
      s1_valid_r <= rd_valid_r;
      if (cmd.scan_start) begin
        dup_r <= 1'b0;
      end else if (hit) begin
        dup_r <= 1'b1;
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= in_op;
      cnt_ins_r <= in_count_insert;
      pair_r    <= {CW'(in_left_x), CW'(in_left_y), CW'(in_right_x), CW'(in_right_y)};
    end
    if (cmd.scan_start) begin
      idx_r <= '0;
    end else if (cmd.scan_issue) begin
      idx_r <= idx_r + AW'(1);
    end
    sq_lx_r <= sq_delta(e_lx, p_lx);
    sq_ly_r <= sq_delta(e_ly, p_ly);
    sq_rx_r <= sq_delta(e_rx, p_rx);
    sq_ry_r <= sq_delta(e_ry, p_ry);
    if (cmd.finish) begin
      out_status_r   <= cmd.status;
      out_stored_r   <= srdt_pkg::COUNT_W'(cnt_nxt);
      out_inserted_r <= srdt_pkg::COUNT_W'(ins_nxt);
    end
  end

  assign stat.op        = op_r;
  assign stat.full      = (cnt_r >= CNT_W'(TABLE_DEPTH)) || (LW'(cnt_r) >= LW'(cap_r));
  assign stat.empty     = (cnt_r == '0);
  assign stat.scan_last = (CNT_W'(idx_r) + CNT_W'(1)) == cnt_r;
  assign stat.pipe_busy = rd_valid_r || s1_valid_r;
  assign stat.dup       = dup_r;
  assign stat.out_free  = !out_valid_r || out_chan.ready;

  assign out_chan.valid          = out_valid_r;
  assign out_chan.status         = out_status_r;
  assign out_chan.stored_count   = out_stored_r;
  assign out_chan.inserted_count = out_inserted_r;

  a_store_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store |-> cnt_r < CNT_W'(TABLE_DEPTH))
    else $error("store beyond table depth");

  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || out_chan.ready))
    else $error("result overwrote an unread result");

  a_ins_le_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    ins_r <= cnt_r)
    else $error("insert counter exceeds stored count");

  a_scan_idx: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_issue |-> CNT_W'(idx_r) < cnt_r)
    else $error("scan read past the last stored entry");

endmodule

// ===== dv/srdt_checker.sv =====
module srdt_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [srdt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [srdt_pkg::CFG_DATA_W-1:0] cfg_data,
  srdt_in_if                              in_chan,
  srdt_out_if                             out_chan,
  output int                              errors,
  output int                              outstanding,
  output int                              dups_seen,
  output int                              fulls_seen
);

  localparam int TABLE_DEPTH = 2048;

  typedef struct packed {
    logic [srdt_pkg::COORD_IN_W-1:0] lx;
    logic [srdt_pkg::COORD_IN_W-1:0] ly;
    logic [srdt_pkg::COORD_IN_W-1:0] rx;
    logic [srdt_pkg::COORD_IN_W-1:0] ry;
  } pair_t;

  typedef struct packed {
    logic [srdt_pkg::STATUS_W-1:0] status;
    logic [srdt_pkg::COUNT_W-1:0]  stored_count;
    logic [srdt_pkg::COUNT_W-1:0]  inserted_count;
  } outcome_t;

  pair_t                       kept_pairs [TABLE_DEPTH];
  int                          kept;
  int                          counted;
  logic [srdt_pkg::CAP_W-1:0]  capacity;
  logic [srdt_pkg::DIST_W-1:0] radius_sq;
  outcome_t                    queued_outcomes [$];
  int                          fail_total;
  int                          dup_total;
  int                          full_total;

  // Exact squared distance; the 64-bit sum cannot overflow for 16-bit coordinates.
  function automatic logic [63:0] dist_sq(input logic [15:0] ax, input logic [15:0] ay,
                                          input logic [15:0] bx, input logic [15:0] by);
    logic [63:0] dx;
    logic [63:0] dy;
    dx = (ax >= bx) ? {48'd0, ax - bx} : {48'd0, bx - ax};
    dy = (ay >= by) ? {48'd0, ay - by} : {48'd0, by - ay};
    return dx * dx + dy * dy;
  endfunction

  task automatic merge_pair(input logic op, input pair_t p, input logic count_it,
                            output outcome_t res);
    int limit;
    int i;
    bit near;
    if (op == srdt_pkg::OP_BEGIN) begin
      kept = 0;
      counted = 0;
      res.status = srdt_pkg::ST_CLEARED;
    end else begin
      limit = (capacity < TABLE_DEPTH) ? int'(capacity) : TABLE_DEPTH;
      if (kept >= limit) begin
        res.status = srdt_pkg::ST_FULL;
      end else begin
        near = 1'b0;
        for (i = 0; i < kept; i++) begin
          if (dist_sq(kept_pairs[i].lx, kept_pairs[i].ly, p.lx, p.ly)
                <= {40'd0, radius_sq} &&
              dist_sq(kept_pairs[i].rx, kept_pairs[i].ry, p.rx, p.ry)
                <= {40'd0, radius_sq})
            near = 1'b1;
        end
        if (near) begin
          res.status = srdt_pkg::ST_DUPLICATE;
        end else begin
          kept_pairs[kept] = p;
          kept++;
          if (count_it)
            counted++;
          res.status = srdt_pkg::ST_STORED;
        end
      end
    end
    res.stored_count   = kept[srdt_pkg::COUNT_W-1:0];
    res.inserted_count = counted[srdt_pkg::COUNT_W-1:0];
  endtask

  always @(posedge clk) begin : watch
    pair_t    p;
    outcome_t want;
    outcome_t got;
    if (!rst_n) begin
      kept = 0;
      counted = 0;
      capacity = srdt_pkg::CAP_RESET;
      radius_sq = srdt_pkg::DIST_RESET;
      queued_outcomes.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == srdt_pkg::CFG_CAPACITY)
          capacity = cfg_data[srdt_pkg::CAP_W-1:0];
        else if (cfg_index == srdt_pkg::CFG_MIN_DIST_SQ)
          radius_sq = cfg_data[srdt_pkg::DIST_W-1:0];
      end
      if (out_chan.valid && out_chan.ready) begin
        got.status         = out_chan.status;
        got.stored_count   = out_chan.stored_count;
        got.inserted_count = out_chan.inserted_count;
        if (queued_outcomes.size() == 0) begin
          $display("%0t: result with no request outstanding: status %0d stored %0d %s %0d",
                   $time, got.status, got.stored_count, "inserted", got.inserted_count);
          fail_total++;
        end else begin
          want = queued_outcomes.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
            fail_total++;
          end
          if (got.stored_count !== want.stored_count) begin
            $display("%0t: stored_count expected %0d, got %0d",
                     $time, want.stored_count, got.stored_count);
            fail_total++;
          end
          if (got.inserted_count !== want.inserted_count) begin
            $display("%0t: inserted_count expected %0d, got %0d",
                     $time, want.inserted_count, got.inserted_count);
            fail_total++;
          end
          if (want.status == srdt_pkg::ST_DUPLICATE)
            dup_total++;
          if (want.status == srdt_pkg::ST_FULL)
            full_total++;
        end
      end
      if (in_chan.valid && in_chan.ready) begin
        p.lx = in_chan.left_x;
        p.ly = in_chan.left_y;
        p.rx = in_chan.right_x;
        p.ry = in_chan.right_y;
        merge_pair(in_chan.op, p, in_chan.count_insert, want);
        queued_outcomes = {queued_outcomes, want};
      end
    end
    errors      <= fail_total;
    outstanding <= queued_outcomes.size();
    dups_seen   <= dup_total;
    fulls_seen  <= full_total;
  end

endmodule

// ===== dv/tb.sv =====
module tb;

  localparam int CYCLE_LIMIT = 1000000;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            cfg_we;
  logic [srdt_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [srdt_pkg::CFG_DATA_W-1:0] cfg_data;

  int errors;
  int outstanding;
  int dups_seen;
  int fulls_seen;
  int gap_max;
  int stall_max;
  int next_gap;
  int cycle_count;
  int requests_sent;
  int settings_used;

  // Coordinates of every pair offered since the last begin, packed {lx, ly, rx, ry}.
  logic [63:0] offered [$];

  srdt_in_if  in_if ();
  srdt_out_if out_if ();

  stereo_pair_radius_dedup_table i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_chan   (in_if),
    .out_chan  (out_if)
  );

  srdt_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_chan     (in_if),
    .out_chan    (out_if),
    .errors      (errors),
    .outstanding (outstanding),
    .dups_seen   (dups_seen),
    .fulls_seen  (fulls_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles.", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side: after each taken result, hold ready low for a random number of cycles.
  always @(posedge clk) begin : drain_side
    int unsigned hold;
    int unsigned stall_left;
    if (!rst_n) begin
      stall_left = 0;
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready)
        hold = $urandom_range(stall_max, 0);
      else
        hold = (stall_left == 0) ? 0 : stall_left - 1;
      stall_left = hold;
      out_if.ready <= (hold == 0);
    end
  end

  function automatic logic [63:0] pts(input int lx, input int ly, input int rx, input int ry);
    return {lx[15:0], ly[15:0], rx[15:0], ry[15:0]};
  endfunction

  function automatic logic [63:0] near_pair(input logic [63:0] base, input int span);
    logic [63:0] p;
    int          off;
    int          k;
    p = base;
    for (k = 0; k < 4; k++) begin
      off = int'($urandom_range(2 * span, 0)) - span;
      p[k*16 +: 16] = p[k*16 +: 16] + off[15:0];
    end
    return p;
  endfunction

  // Valid stays high when the next request follows with no gap.
  task automatic push_request(input logic op, input logic [63:0] coords, input logic count_it);
    repeat (next_gap) @(posedge clk);
    in_if.valid        <= 1'b1;
    in_if.op           <= op;
    in_if.left_x       <= coords[63:48];
    in_if.left_y       <= coords[47:32];
    in_if.right_x      <= coords[31:16];
    in_if.right_y      <= coords[15:0];
    in_if.count_insert <= count_it;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    requests_sent++;
    if (op == srdt_pkg::OP_BEGIN)
      offered.delete();
    else
      offered = {offered, coords};
    next_gap = $urandom_range(gap_max, 0);
    if (next_gap != 0)
      in_if.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    if (next_gap == 0)
      in_if.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic set_reg(input logic [srdt_pkg::CFG_IDX_W-1:0] idx,
                         input logic [srdt_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // The capacity write carries random upper bits, which the block must ignore.
  task automatic apply_setting(input int unsigned cap, input int unsigned rad);
    logic [srdt_pkg::CFG_DATA_W-1:0] word;
    wait_drained();
    word = srdt_pkg::CFG_DATA_W'($urandom);
    word[srdt_pkg::CAP_W-1:0] = cap[srdt_pkg::CAP_W-1:0];
    set_reg(srdt_pkg::CFG_CAPACITY, word);
    set_reg(srdt_pkg::CFG_MIN_DIST_SQ, rad[srdt_pkg::CFG_DATA_W-1:0]);
    settings_used++;
  endtask

  initial begin : stimulus
    int          phase;
    int          n;
    int          roll;
    int          span;
    int unsigned cap;
    int unsigned rad;
    logic [63:0] spot;

    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = srdt_pkg::CFG_CAPACITY;
    cfg_data           = '0;
    in_if.valid        = 1'b0;
    in_if.op           = srdt_pkg::OP_BEGIN;
    in_if.left_x       = '0;
    in_if.left_y       = '0;
    in_if.right_x      = '0;
    in_if.right_y      = '0;
    in_if.count_insert = 1'b0;
    requests_sent      = 0;
    settings_used      = 1;
    next_gap           = 0;
    gap_max            = 3;
    stall_max          = 3;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: capacity 320, radius of 64 pixels.
    push_request(srdt_pkg::OP_OFFER, pts(0, 0, 0, 0), 1'b1);
    push_request(srdt_pkg::OP_OFFER, pts(0, 0, 0, 0), 1'b1);
    push_request(srdt_pkg::OP_OFFER, pts(64, 0, 0, 0), 1'b1);
    push_request(srdt_pkg::OP_OFFER, pts(65, 0, 0, 0), 1'b0);
    push_request(srdt_pkg::OP_OFFER, pts(0, 0, 0, 64), 1'b1);
    push_request(srdt_pkg::OP_OFFER, pts(45, 45, 45, 45), 1'b1);
    push_request(srdt_pkg::OP_OFFER, pts(0, 0, 500, 500), 1'b1);
    push_request(srdt_pkg::OP_OFFER, pts(65535, 65535, 65535, 65535), 1'b1);
    push_request(srdt_pkg::OP_OFFER, pts(65535, 0, 0, 65535), 1'b1);
    // A begin ignores its coordinate and count fields.
    push_request(srdt_pkg::OP_BEGIN, {$urandom(), $urandom()}, 1'b1);
    push_request(srdt_pkg::OP_OFFER, pts(65535, 65535, 65535, 65535), 1'b0);

    // One slot already taken: an exact repeat must come back full, not duplicate.
    apply_setting(1, 0);
    push_request(srdt_pkg::OP_OFFER, pts(65535, 65535, 65535, 65535), 1'b1);
    push_request(srdt_pkg::OP_OFFER, pts(1234, 567, 890, 4321), 1'b1);
    push_request(srdt_pkg::OP_BEGIN, pts(0, 0, 0, 0), 1'b0);
    push_request(srdt_pkg::OP_OFFER, pts(1234, 567, 890, 4321), 1'b1);
    apply_setting(2, 0);
    push_request(srdt_pkg::OP_OFFER, pts(1234, 567, 890, 4321), 1'b1);
    push_request(srdt_pkg::OP_OFFER, pts(1235, 567, 890, 4321), 1'b1);
    push_request(srdt_pkg::OP_OFFER, {$urandom(), $urandom()}, 1'b1);

    apply_setting(0, 4096);
    push_request(srdt_pkg::OP_OFFER, {$urandom(), $urandom()}, 1'b1);
    push_request(srdt_pkg::OP_BEGIN, {$urandom(), $urandom()}, 1'b0);
    push_request(srdt_pkg::OP_OFFER, pts(0, 0, 0, 0), 1'b1);

    // Capacity beyond the table depth, widest radius.
    apply_setting(4095, 24'hFFFFFF);
    push_request(srdt_pkg::OP_OFFER, pts(0, 0, 0, 0), 1'b1);
    push_request(srdt_pkg::OP_OFFER, pts(4096, 0, 0, 0), 1'b1);
    push_request(srdt_pkg::OP_OFFER, pts(4095, 0, 0, 0), 1'b1);
    push_request(srdt_pkg::OP_OFFER, pts(0, 0, 0, 0), 1'b0);

    for (phase = 0; phase < 9; phase++) begin
      case (phase)
        0: begin cap = 320;  rad = 4096;     end
        1: begin cap = 3;    rad = 65536;    end
        2: begin cap = 0;    rad = 0;        end
        3: begin cap = 12;   rad = 256;      end
        4: begin cap = 2048; rad = 24'hFFFFFF; end
        5: begin cap = 1;    rad = 1;        end
        6: begin cap = 4095; rad = $urandom_range(24'hFFFFFF, 0); end
        default: begin
          cap = $urandom_range(40, 1);
          rad = $urandom_range(20000, 0);
        end
      endcase
      apply_setting(cap, rad);
      gap_max   = (phase % 3 == 1) ? 0 : 9;
      stall_max = (phase % 3 == 2) ? 0 : 9;
      for (n = 0; n < 30; n++) begin
        roll = $urandom_range(99, 0);
        if (n == 0 || roll < 6) begin
          push_request(srdt_pkg::OP_BEGIN, {$urandom(), $urandom()},
                       1'($urandom_range(1, 0)));
        end else if (offered.size() != 0 && roll < 65) begin
          case ($urandom_range(5, 0))
            0: span = 0;
            1: span = 1;
            2: span = 16;
            3: span = 48;
            4: span = 70;
            default: span = 600;
          endcase
          spot = near_pair(offered[$urandom_range(offered.size() - 1, 0)], span);
          push_request(srdt_pkg::OP_OFFER, spot, 1'($urandom_range(1, 0)));
        end else begin
          push_request(srdt_pkg::OP_OFFER, {$urandom(), $urandom()},
                       1'($urandom_range(1, 0)));
        end
        // Let the block go fully idle in the middle of a merge once.
        if (phase == 4 && n == 15)
          wait_drained();
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Ran %0d requests under %0d register settings,", requests_sent, settings_used);
    $display("capacity 0 to 4095 and radius 0 to max; saw %0d duplicate and %0d full drops.",
             dups_seen, fulls_seen);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
